@@ sv/cgt_pkg.sv @@
`timescale 1ns / 1ps
// cgt_pkg: register indexes and shared types for the complex transposed GEMV column block.
// No dependencies; used by cgt_mac, cgt_scale and complex_gemv_transposed_column.
package cgt_pkg;

   localparam int CSR_IDX_BITS = 2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_ALPHA_RE    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ALPHA_IM    = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CONJ_MATRIX = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CONJ_RESULT = 2'd3;

   // conj_elem: use conj(a)*x per element; conj_sum: conjugate the column sum
   typedef struct packed {
      logic conj_elem;
      logic conj_sum;
   } cfg_flags_type;

endpackage

@@ sv/cgt_mac.sv @@
`timescale 1ns / 1ps
// cgt_mac: input register, complex element product and saturating column accumulator.
// Depends on cgt_pkg; hands each finished column sum to cgt_scale.
module cgt_mac #(
   parameter int SAMPLE_BITS = 16,
   parameter int ACC_BITS    = 48
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cgt_pkg::cfg_flags_type        cfg,
   input  logic                          in_valid,
   output logic                          in_stall,
   input  logic signed [SAMPLE_BITS-1:0] in_mat_re,
   input  logic signed [SAMPLE_BITS-1:0] in_mat_im,
   input  logic signed [SAMPLE_BITS-1:0] in_vec_re,
   input  logic signed [SAMPLE_BITS-1:0] in_vec_im,
   input  logic signed [SAMPLE_BITS-1:0] in_y_re,
   input  logic signed [SAMPLE_BITS-1:0] in_y_im,
   input  logic                          in_last,
   output logic                          tot_valid,
   input  logic                          tot_stall,
   output logic signed [ACC_BITS-1:0]    tot_re,
   output logic signed [ACC_BITS-1:0]    tot_im,
   output logic signed [SAMPLE_BITS-1:0] tot_y_re,
   output logic signed [SAMPLE_BITS-1:0] tot_y_im,
   output logic                          tot_sat
);
   import cgt_pkg::*;

   localparam int PB = 2 * SAMPLE_BITS;
   localparam int TB = PB + 1;
   localparam int SW = ((ACC_BITS > TB) ? ACC_BITS : TB) + 1;
   localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

   // stage 1: input word
   logic                          s1_valid_ff;
   logic signed [SAMPLE_BITS-1:0] s1_mat_re_ff, s1_mat_im_ff, s1_vec_re_ff, s1_vec_im_ff;
   logic signed [SAMPLE_BITS-1:0] s1_y_re_ff, s1_y_im_ff;
   logic                          s1_last_ff;

   // stage 2: element product
   logic                          s2_valid_ff;
   logic signed [TB-1:0]          s2_t_re_ff, s2_t_im_ff;
   logic signed [TB-1:0]          s2_t_re_in, s2_t_im_in;
   logic signed [SAMPLE_BITS-1:0] s2_y_re_ff, s2_y_im_ff;
   logic                          s2_last_ff;

   // accumulator and column total
   logic signed [ACC_BITS-1:0]    acc_re_ff, acc_im_ff;
   logic                          sat_seen_ff;
   logic                          s3_valid_ff;
   logic signed [ACC_BITS-1:0]    s3_re_ff, s3_im_ff;
   logic signed [SAMPLE_BITS-1:0] s3_y_re_ff, s3_y_im_ff;
   logic                          s3_sat_ff;

   logic signed [PB-1:0]          p_rr, p_ii, p_ri, p_ir;
   logic signed [SW-1:0]          sum_re, sum_im;
   logic                          ovf_re, ovf_im;
   logic signed [ACC_BITS-1:0]    acc_re_in, acc_im_in;

   logic s3_free, s2_move, s2_free, s1_free;

   assign s3_free  = !s3_valid_ff || !tot_stall;
   assign s2_move  = s2_valid_ff && (!s2_last_ff || s3_free);
   assign s2_free  = !s2_valid_ff || s2_move;
   assign s1_free  = !s1_valid_ff || s2_free;
   assign in_stall = !s1_free;

   always_comb begin
      p_rr = s1_mat_re_ff * s1_vec_re_ff;
      p_ii = s1_mat_im_ff * s1_vec_im_ff;
      p_ri = s1_mat_re_ff * s1_vec_im_ff;
      p_ir = s1_mat_im_ff * s1_vec_re_ff;
      s2_t_re_in = TB'(p_rr) + (cfg.conj_elem ? TB'(p_ii) : -TB'(p_ii));
      s2_t_im_in = TB'(p_ri) + (cfg.conj_elem ? -TB'(p_ir) : TB'(p_ir));
   end

   always_comb begin
      sum_re = SW'(acc_re_ff) + SW'(s2_t_re_ff);
      sum_im = SW'(acc_im_ff) + SW'(s2_t_im_ff);
      ovf_re = !((&sum_re[SW-1:ACC_BITS-1]) || !(|sum_re[SW-1:ACC_BITS-1]));
      ovf_im = !((&sum_im[SW-1:ACC_BITS-1]) || !(|sum_im[SW-1:ACC_BITS-1]));
      acc_re_in = ovf_re ? (sum_re[SW-1] ? ACC_MIN : ACC_MAX) : sum_re[ACC_BITS-1:0];
      acc_im_in = ovf_im ? (sum_im[SW-1] ? ACC_MIN : ACC_MAX) : sum_im[ACC_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         acc_re_ff   <= '0;
         acc_im_ff   <= '0;
         sat_seen_ff <= 1'b0;
      end else begin
         if (s1_free) s1_valid_ff <= in_valid;
         if (s2_free) s2_valid_ff <= s1_valid_ff;
         if (s3_free) s3_valid_ff <= s2_move && s2_last_ff;
         if (s2_move) begin
            if (s2_last_ff) begin
               acc_re_ff   <= '0;
               acc_im_ff   <= '0;
               sat_seen_ff <= 1'b0;
            end else begin
               acc_re_ff   <= acc_re_in;
               acc_im_ff   <= acc_im_in;
               sat_seen_ff <= sat_seen_ff || ovf_re || ovf_im;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && s1_free) begin
         s1_mat_re_ff <= in_mat_re;
         s1_mat_im_ff <= in_mat_im;
         s1_vec_re_ff <= in_vec_re;
         s1_vec_im_ff <= in_vec_im;
         s1_y_re_ff   <= in_y_re;
         s1_y_im_ff   <= in_y_im;
         s1_last_ff   <= in_last;
      end
      if (s1_valid_ff && s2_free) begin
         s2_t_re_ff <= s2_t_re_in;
         s2_t_im_ff <= s2_t_im_in;
         s2_y_re_ff <= s1_y_re_ff;
         s2_y_im_ff <= s1_y_im_ff;
         s2_last_ff <= s1_last_ff;
      end
      if (s2_move && s2_last_ff) begin
         s3_re_ff   <= acc_re_in;
         s3_im_ff   <= acc_im_in;
         s3_y_re_ff <= s2_y_re_ff;
         s3_y_im_ff <= s2_y_im_ff;
         s3_sat_ff  <= sat_seen_ff || ovf_re || ovf_im;
      end
   end

   assign tot_valid = s3_valid_ff;
   assign tot_re    = s3_re_ff;
   assign tot_im    = s3_im_ff;
   assign tot_y_re  = s3_y_re_ff;
   assign tot_y_im  = s3_y_im_ff;
   assign tot_sat   = s3_sat_ff;

endmodule

@@ sv/cgt_scale.sv @@
`timescale 1ns / 1ps
// cgt_scale: alpha scaling of the column sum, y update, rounding and saturation to a sample.
// Depends on cgt_pkg; fed by cgt_mac, drives the result word registers.
module cgt_scale #(
   parameter int SAMPLE_BITS = 16,
   parameter int ACC_BITS    = 48
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cgt_pkg::cfg_flags_type        cfg,
   input  logic signed [SAMPLE_BITS-1:0] alpha_re,
   input  logic signed [SAMPLE_BITS-1:0] alpha_im,
   input  logic                          tot_valid,
   output logic                          tot_stall,
   input  logic signed [ACC_BITS-1:0]    tot_re,
   input  logic signed [ACC_BITS-1:0]    tot_im,
   input  logic signed [SAMPLE_BITS-1:0] tot_y_re,
   input  logic signed [SAMPLE_BITS-1:0] tot_y_im,
   input  logic                          tot_sat,
   output logic                          out_valid,
   input  logic                          out_stall,
   output logic signed [SAMPLE_BITS-1:0] out_y_re,
   output logic signed [SAMPLE_BITS-1:0] out_y_im,
   output logic                          out_sat
);
   import cgt_pkg::*;

   localparam int FB = 2 * (SAMPLE_BITS - 1);
   localparam int PW = SAMPLE_BITS + ACC_BITS;
   localparam int YW = SAMPLE_BITS + FB;
   localparam int TW = ((PW + 1 > YW) ? PW + 1 : YW) + 2;
   localparam logic signed [TW-1:0] HALF = {{(TW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};
   localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic                          s4_valid_ff;
   logic signed [PW-1:0]          arfr_ff, aifi_ff, arfi_ff, aifr_ff;
   logic signed [SAMPLE_BITS-1:0] s4_y_re_ff, s4_y_im_ff;
   logic                          s4_sat_ff;

   logic                          out_valid_ff;
   logic signed [SAMPLE_BITS-1:0] out_y_re_ff, out_y_im_ff;
   logic                          out_sat_ff;

   logic signed [TW-1:0]          tot_re_w, tot_im_w;
   logic                          ovf_re, ovf_im;
   logic signed [SAMPLE_BITS-1:0] out_y_re_in, out_y_im_in;

   logic out_free, s4_free;

   assign out_free  = !out_valid_ff || !out_stall;
   assign s4_free   = !s4_valid_ff || out_free;
   assign tot_stall = !s4_free;

   always_comb begin
      tot_re_w = TW'(arfr_ff) + (cfg.conj_sum ? TW'(aifi_ff) : -TW'(aifi_ff))
               + (TW'(s4_y_re_ff) <<< FB) + HALF;
      tot_im_w = (cfg.conj_sum ? -TW'(arfi_ff) : TW'(arfi_ff)) + TW'(aifr_ff)
               + (TW'(s4_y_im_ff) <<< FB) + HALF;
      ovf_re = !((&tot_re_w[TW-1:FB+SAMPLE_BITS-1]) || !(|tot_re_w[TW-1:FB+SAMPLE_BITS-1]));
      ovf_im = !((&tot_im_w[TW-1:FB+SAMPLE_BITS-1]) || !(|tot_im_w[TW-1:FB+SAMPLE_BITS-1]));
      out_y_re_in = ovf_re ? (tot_re_w[TW-1] ? S_MIN : S_MAX)
                           : tot_re_w[FB+SAMPLE_BITS-1:FB];
      out_y_im_in = ovf_im ? (tot_im_w[TW-1] ? S_MIN : S_MAX)
                           : tot_im_w[FB+SAMPLE_BITS-1:FB];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s4_free)  s4_valid_ff  <= tot_valid;
         if (out_free) out_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (tot_valid && s4_free) begin
         arfr_ff    <= alpha_re * tot_re;
         aifi_ff    <= alpha_im * tot_im;
         arfi_ff    <= alpha_re * tot_im;
         aifr_ff    <= alpha_im * tot_re;
         s4_y_re_ff <= tot_y_re;
         s4_y_im_ff <= tot_y_im;
         s4_sat_ff  <= tot_sat;
      end
      if (s4_valid_ff && out_free) begin
         out_y_re_ff <= out_y_re_in;
         out_y_im_ff <= out_y_im_in;
         out_sat_ff  <= s4_sat_ff || ovf_re || ovf_im;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_y_re  = out_y_re_ff;
   assign out_y_im  = out_y_im_ff;
   assign out_sat   = out_sat_ff;

endmodule

@@ sv/complex_gemv_transposed_column.sv @@
`timescale 1ns / 1ps
// complex_gemv_transposed_column: top level with control registers, accumulator and scaler.
// Depends on cgt_pkg, cgt_mac and cgt_scale.
//
// Takes one word per cycle while req_stall is low: a complex matrix element, a complex vector
// element, the old y and a last flag. Each word's complex product (conjugated per the conj
// settings) is added into a saturating ACC_BITS accumulator; on a word marked last the block
// forms alpha times the column sum (conjugated when CONJ_RESULT is set), adds y, rounds to a
// Q1.15 sample with saturation and sends one result word. Words carry no result otherwise.
// The sustained rate is one word per clock, set by the accumulate loop. Write the control
// registers only while no column is in flight.
module complex_gemv_transposed_column #(
   parameter int SAMPLE_BITS = 16,
   parameter int ACC_BITS    = 48
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [cgt_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [SAMPLE_BITS-1:0]           csr_wdata,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [SAMPLE_BITS-1:0]    req_mat_re,
   input  logic signed [SAMPLE_BITS-1:0]    req_mat_im,
   input  logic signed [SAMPLE_BITS-1:0]    req_vec_re,
   input  logic signed [SAMPLE_BITS-1:0]    req_vec_im,
   input  logic signed [SAMPLE_BITS-1:0]    req_y_in_re,
   input  logic signed [SAMPLE_BITS-1:0]    req_y_in_im,
   input  logic                             req_last_elem,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]    rsp_y_out_re,
   output logic signed [SAMPLE_BITS-1:0]    rsp_y_out_im,
   output logic                             rsp_saturated
);
   import cgt_pkg::*;

   localparam logic signed [SAMPLE_BITS-1:0] ALPHA_ONE = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

   logic signed [SAMPLE_BITS-1:0] alpha_re_ff, alpha_im_ff;
   logic                          conj_matrix_ff, conj_result_ff;
   cfg_flags_type                 cfg;

   logic                          tot_valid, tot_stall, tot_sat;
   logic signed [ACC_BITS-1:0]    tot_re, tot_im;
   logic signed [SAMPLE_BITS-1:0] tot_y_re, tot_y_im;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_re_ff    <= ALPHA_ONE;
         alpha_im_ff    <= '0;
         conj_matrix_ff <= 1'b0;
         conj_result_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ALPHA_RE:    alpha_re_ff    <= csr_wdata;
            CSR_ALPHA_IM:    alpha_im_ff    <= csr_wdata;
            CSR_CONJ_MATRIX: conj_matrix_ff <= csr_wdata[0];
            CSR_CONJ_RESULT: conj_result_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign cfg.conj_elem = conj_matrix_ff ^ conj_result_ff;
   assign cfg.conj_sum  = conj_result_ff;

   cgt_mac #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .ACC_BITS    (ACC_BITS)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_mat_re (req_mat_re),
      .in_mat_im (req_mat_im),
      .in_vec_re (req_vec_re),
      .in_vec_im (req_vec_im),
      .in_y_re   (req_y_in_re),
      .in_y_im   (req_y_in_im),
      .in_last   (req_last_elem),
      .tot_valid (tot_valid),
      .tot_stall (tot_stall),
      .tot_re    (tot_re),
      .tot_im    (tot_im),
      .tot_y_re  (tot_y_re),
      .tot_y_im  (tot_y_im),
      .tot_sat   (tot_sat)
   );

   cgt_scale #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .ACC_BITS    (ACC_BITS)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .alpha_re  (alpha_re_ff),
      .alpha_im  (alpha_im_ff),
      .tot_valid (tot_valid),
      .tot_stall (tot_stall),
      .tot_re    (tot_re),
      .tot_im    (tot_im),
      .tot_y_re  (tot_y_re),
      .tot_y_im  (tot_y_im),
      .tot_sat   (tot_sat),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_y_re  (rsp_y_out_re),
      .out_y_im  (rsp_y_out_im),
      .out_sat   (rsp_saturated)
   );

endmodule
